@@ design/ssb_pkg.sv @@
// ssb_pkg: shared constants and the sequencer state type of the byte selection sorter.
// No dependencies; imported by selection_sort_bytes_top.
package ssb_pkg;

    localparam int CAPACITY = 64;                     // bytes held per batch
    localparam int IDX_W    = $clog2(CAPACITY);       // store address width
    localparam int CNT_W    = $clog2(CAPACITY + 1);   // fill count, holds CAPACITY itself
    localparam int BYTE_W   = 8;

    typedef enum logic [2:0] {
        ST_LOAD,      // take beats into the store
        ST_SCAN,      // stream the unsorted prefix through the max compare
        ST_SWAP_A,    // write end byte into the max position
        ST_SWAP_B,    // write max byte into the end position
        ST_EMIT_RD,   // fetch the next sorted byte
        ST_EMIT_OUT   // present it until taken
    } t_state;

endpackage

@@ design/selection_sort_bytes_top.sv @@
// selection_sort_bytes_top: batch selection sorter for unsigned bytes.
// Load one byte per beat, ready whenever the block is loading.
// Sort on the last beat: for each end position t from n-1 down to 1, a scan of t+1
// registered reads through one compare unit finds the max, then two swap writes follow.
// Emit n sorted bytes, each fetched from the store and then held until the sink takes it; then load again.
// Reset (synchronous, active low) empties the store count and returns to loading.
module selection_sort_bytes_top (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    // slave side
    input  logic                       i_s_tvalid,
    output logic                       o_s_tready,
    input  logic [ssb_pkg::BYTE_W-1:0] i_s_tdata,   // [7:0] element_value
    input  logic                       i_s_tlast,   // final_element
    // master side
    output logic                       o_m_tvalid,
    input  logic                       i_m_tready,
    output logic [ssb_pkg::BYTE_W-1:0] o_m_tdata,   // [7:0] sorted_value
    output logic                       o_m_tlast    // final_result
);
    import ssb_pkg::*;

    // Byte store: one write port, two registered read ports.
    logic [BYTE_W-1:0] r_store [CAPACITY];

    t_state            r_state, n_state;
    logic [CNT_W-1:0]  r_count, n_count;      // bytes held in this batch
    logic [IDX_W-1:0]  r_top, n_top;          // end of the unsorted prefix
    logic [IDX_W-1:0]  r_last_idx, n_last_idx;// index of the last sorted byte
    logic [IDX_W-1:0]  r_scan, n_scan;        // read address: scan and emit
    logic              r_issuing, n_issuing;  // scan reads still to issue
    logic              r_pend, n_pend;        // read data of r_pend_idx is in r_rd_a
    logic [IDX_W-1:0]  r_pend_idx, n_pend_idx;
    logic [IDX_W-1:0]  r_best_idx, n_best_idx;
    logic [BYTE_W-1:0] r_best_val, n_best_val;
    logic [BYTE_W-1:0] r_rd_a;                // registered read of store[r_scan]
    logic [BYTE_W-1:0] r_rd_b;                // registered read of store[r_top]

    logic              in_beat, out_beat;
    logic              has_room;
    logic [CNT_W-1:0]  batch_cnt;             // count including the current beat, saturating at CAPACITY
    logic              scan_done;
    logic              wr_en;
    logic [IDX_W-1:0]  wr_addr;
    logic [BYTE_W-1:0] wr_data;

    assign in_beat   = i_s_tvalid & o_s_tready;
    assign out_beat  = o_m_tvalid & i_m_tready;
    assign has_room  = (r_count < CNT_W'(CAPACITY));
    assign batch_cnt = has_room ? (r_count + CNT_W'(1)) : r_count;
    // The last compare of a pass sees the end position itself.
    assign scan_done = r_pend && (r_pend_idx == r_top);

    // ---------------------------------------------------------------
    // Next state
    // ---------------------------------------------------------------
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_LOAD: begin
                if (in_beat && i_s_tlast) begin
                    // a single byte is already sorted
                    n_state = (batch_cnt == CNT_W'(1)) ? ST_EMIT_RD : ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (scan_done) begin
                    n_state = ST_SWAP_A;
                end
            end
            ST_SWAP_A: begin
                n_state = ST_SWAP_B;
            end
            ST_SWAP_B: begin
                n_state = (r_top == IDX_W'(1)) ? ST_EMIT_RD : ST_SCAN;
            end
            ST_EMIT_RD: begin
                n_state = ST_EMIT_OUT;
            end
            ST_EMIT_OUT: begin
                if (out_beat) begin
                    n_state = o_m_tlast ? ST_LOAD : ST_EMIT_RD;
                end
            end
            default: begin
                n_state = ST_LOAD;
            end
        endcase
    end

    // ---------------------------------------------------------------
    // Outputs and store write port
    // ---------------------------------------------------------------
    always_comb begin
        o_s_tready = 1'b0;
        o_m_tvalid = 1'b0;
        wr_en      = 1'b0;
        wr_addr    = r_count[IDX_W-1:0];
        wr_data    = i_s_tdata;
        case (r_state)
            ST_LOAD: begin
                o_s_tready = 1'b1;
                // drop bytes once the store is full
                wr_en      = in_beat && has_room;
            end
            ST_SWAP_A: begin
                // old end byte goes where the max was found
                wr_en   = 1'b1;
                wr_addr = r_best_idx;
                wr_data = r_rd_b;
            end
            ST_SWAP_B: begin
                wr_en   = 1'b1;
                wr_addr = r_top;
                wr_data = r_best_val;
            end
            ST_EMIT_OUT: begin
                o_m_tvalid = 1'b1;
            end
            default: begin
                wr_en = 1'b0;
            end
        endcase
    end

    assign o_m_tdata = r_rd_a;
    assign o_m_tlast = (r_scan == r_last_idx);

    // ---------------------------------------------------------------
    // Datapath next values
    // ---------------------------------------------------------------
    always_comb begin
        n_count    = r_count;
        n_top      = r_top;
        n_last_idx = r_last_idx;
        n_scan     = r_scan;
        n_issuing  = 1'b0;
        n_pend     = 1'b0;
        n_pend_idx = r_scan;
        n_best_idx = r_best_idx;
        n_best_val = r_best_val;
        case (r_state)
            ST_LOAD: begin
                if (in_beat) begin
                    n_count = batch_cnt;
                    if (i_s_tlast) begin
                        n_top      = IDX_W'(batch_cnt - CNT_W'(1));
                        n_last_idx = IDX_W'(batch_cnt - CNT_W'(1));
                        n_scan     = '0;
                        n_issuing  = 1'b1;
                    end
                end
            end
            ST_SCAN: begin
                // issue one read a cycle up to the end position
                n_pend    = r_issuing;
                n_issuing = r_issuing && (r_scan != r_top);
                if (r_issuing) begin
                    n_scan = r_scan + IDX_W'(1);
                end
                // strict compare keeps the first-occurring maximum
                if (r_pend && ((r_pend_idx == '0) || (r_rd_a > r_best_val))) begin
                    n_best_idx = r_pend_idx;
                    n_best_val = r_rd_a;
                end
            end
            ST_SWAP_B: begin
                n_top     = r_top - IDX_W'(1);
                n_scan    = '0;
                n_issuing = 1'b1;
            end
            ST_EMIT_OUT: begin
                if (out_beat) begin
                    if (o_m_tlast) begin
                        n_count = '0;
                    end else begin
                        n_scan = r_scan + IDX_W'(1);
                    end
                end
            end
            default: begin
                n_scan = r_scan;
            end
        endcase
    end

    // ---------------------------------------------------------------
    // Registers
    // ---------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_LOAD;
            r_count   <= '0;
            r_issuing <= 1'b0;
            r_pend    <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_issuing <= n_issuing;
            r_pend    <= n_pend;
        end
    end

    always_ff @(posedge i_clk) begin
        r_top      <= n_top;
        r_last_idx <= n_last_idx;
        r_scan     <= n_scan;
        r_pend_idx <= n_pend_idx;
        r_best_idx <= n_best_idx;
        r_best_val <= n_best_val;
    end

    // Store: write port plus two registered reads
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_store[wr_addr] <= wr_data;
        end
        r_rd_a <= r_store[r_scan];
        r_rd_b <= r_store[r_top];
    end

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------
    // A result only ever comes from a non-empty batch and a held index.
    a_emit_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (r_count != '0) && (r_scan <= r_last_idx))
        else $error("emit index outside the batch");

    // The max found by a pass lies inside the unsorted prefix.
    a_best_in_prefix: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SWAP_A) |-> (r_best_idx <= r_top))
        else $error("max index beyond end position");

    // The store is frozen while it is scanned or read out.
    a_no_write_on_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == ST_SCAN) || (r_state == ST_EMIT_RD) || (r_state == ST_EMIT_OUT))
            |-> !wr_en)
        else $error("store written during scan or emit");

    // After the last sorted beat the block takes input again with an empty store.
    a_reload_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_beat && o_m_tlast) |=> o_s_tready && (r_count == '0))
        else $error("block not reloading after last beat");

endmodule
